[hw/rtl/backward_rle_fill_copy_decoder_core_assert.svh]
// assertion macros shared by the decoder rtl
`ifndef BACKWARD_RLE_FILL_COPY_DECODER_CORE_ASSERT_SVH
`define BACKWARD_RLE_FILL_COPY_DECODER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BRFC_ASSERT_IMPLY(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define BRFC_ASSERT_NEXT(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/brfc_pkg.sv]
// package: types and constants for the backward run-length decoder
`timescale 1ns / 1ps
`default_nettype none
package brfc_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned PARA_W  = 16;
   localparam int unsigned CAP_W   = PARA_W + 4;
   localparam int unsigned PROD_W  = CAP_W + 1;
   localparam int unsigned ERR_W   = 2;

   localparam logic [BYTE_W-1:0] PAD_BYTE = 8'hFF;
   localparam logic [BYTE_W-1:0] OP_FILL  = 8'hB0;
   localparam logic [BYTE_W-1:0] OP_COPY  = 8'hB2;

   typedef enum logic [2:0] {
      PH_SKIP    = 3'd0,
      PH_OPCODE  = 3'd1,
      PH_CNT_HI  = 3'd2,
      PH_CNT_LO  = 3'd3,
      PH_FILL    = 3'd4,
      PH_LITERAL = 3'd5,
      PH_TAIL    = 3'd6,
      PH_DRAIN   = 3'd7
   } phase_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE     = 2'd0,
      ERR_OVERFLOW = 2'd1,
      ERR_OPCODE   = 2'd2,
      ERR_EARLY    = 2'd3
   } err_type;

   typedef struct packed {
      logic [BYTE_W-1:0] packed_byte;
      logic              last_byte;
   } in_beat_type;

   typedef struct packed {
      logic               valid;
      logic [BYTE_W-1:0]  out_byte;
      logic [COUNT_W-1:0] repeat_res;
      logic               done_res;
      err_type            error;
   } res_type;

endpackage
`default_nettype wire

[hw/rtl/backward_rle_fill_copy_decoder_core.sv]
// top level: input register, command parser and result register
// a beat waits in the input register until the result register can take its result
// throughput: one input beat per cycle, limited only by the parser step
// a beat with nothing to report is consumed without a result beat
// reset (synchronous, active high) clears the parser to padding skip,
// empties both registers and sets the paragraph limit to zero
`timescale 1ns / 1ps
`default_nettype none
`include "backward_rle_fill_copy_decoder_core_assert.svh"
module backward_rle_fill_copy_decoder_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [brfc_pkg::BYTE_W-1:0]   req_packed_byte,
   input  wire logic                          req_last_byte,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [brfc_pkg::BYTE_W-1:0]   rsp_out_byte,
   output      logic [brfc_pkg::COUNT_W-1:0]  rsp_repeat_res,
   output      logic                          rsp_done_res,
   output      logic [brfc_pkg::ERR_W-1:0]    rsp_error,
   input  wire logic                          csr_wr_en,
   input  wire logic [brfc_pkg::PARA_W-1:0]   csr_wr_data
);

   logic [brfc_pkg::PARA_W-1:0] dest_ff, dest_in;
   brfc_pkg::in_beat_type       req_beat, beat;
   logic                        beat_valid, out_free, step;
   brfc_pkg::res_type           res, rsp_res;
   logic                        rsp_hard_err, rsp_err_clean, rsp_mid, rsp_mid_data;
   logic                        beat_stall;

   assign req_beat.packed_byte = req_packed_byte;
   assign req_beat.last_byte   = req_last_byte;
   assign step                 = beat_valid && out_free;
   assign dest_in              = csr_wr_en ? csr_wr_data : dest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_ff <= '0;
      end else begin
         dest_ff <= dest_in;
      end
   end

   brfc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_beat   (req_beat),
      .take       (step),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   brfc_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .beat            (beat),
      .dest_paragraphs (dest_ff),
      .res             (res)
   );

   brfc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .res       (res),
      .rsp_ready (rsp_ready),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_res   (rsp_res)
   );

   assign rsp_out_byte   = rsp_res.out_byte;
   assign rsp_repeat_res = rsp_res.repeat_res;
   assign rsp_done_res   = rsp_res.done_res;
   assign rsp_error      = rsp_res.error;

   assign rsp_hard_err  = rsp_valid && (rsp_error != brfc_pkg::ERR_NONE)
                          && (rsp_error != brfc_pkg::ERR_EARLY);
   assign rsp_err_clean = rsp_done_res && (rsp_repeat_res == '0) && (rsp_out_byte == '0);
   assign rsp_mid       = rsp_valid && !rsp_done_res;
   assign rsp_mid_data  = (rsp_repeat_res != '0) && (rsp_error == brfc_pkg::ERR_NONE);
   assign beat_stall    = beat_valid && !out_free;

   `BRFC_ASSERT_IMPLY(a_err_payload, rsp_hard_err, rsp_err_clean, "error beat carries data")
   `BRFC_ASSERT_IMPLY(a_mid_emits, rsp_mid, rsp_mid_data, "non-final beat without data")
   `BRFC_ASSERT_NEXT(a_beat_held, beat_stall, beat_valid && $stable(beat), "stalled beat lost")

endmodule
`default_nettype wire

[hw/rtl/brfc_in_reg.sv]
// input register: holds one accepted request beat for the parser
`timescale 1ns / 1ps
`default_nettype none
module brfc_in_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire brfc_pkg::in_beat_type req_beat,
   input  wire logic                take,
   output      logic                beat_valid,
   output      brfc_pkg::in_beat_type beat
);

   logic                  valid_ff, valid_in;
   brfc_pkg::in_beat_type beat_ff, beat_in;

   assign req_ready  = !valid_ff || take;
   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         beat_in  = req_beat;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

endmodule
`default_nettype wire

[hw/rtl/brfc_parser.sv]
// command parser: stream state, capacity checks and result forming
`timescale 1ns / 1ps
`default_nettype none
`include "backward_rle_fill_copy_decoder_core_assert.svh"
module brfc_parser (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           step,
   input  wire brfc_pkg::in_beat_type          beat,
   input  wire logic [brfc_pkg::PARA_W-1:0]    dest_paragraphs,
   output      brfc_pkg::res_type              res
);

   brfc_pkg::phase_type                 phase_ff, phase_in;
   logic                                final_ff, final_in;
   logic                                fill_ff, fill_in;
   logic [brfc_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic [brfc_pkg::PROD_W-1:0]         prod_ff, prod_in;

   logic [brfc_pkg::BYTE_W-1:0]         b;
   logic                                last;
   logic [brfc_pkg::PROD_W-1:0]         cap;
   logic [brfc_pkg::PROD_W-1:0]         sum_fill;
   logic [brfc_pkg::PROD_W-1:0]         sum_lit;
   logic                                fill_ovf, lit_ovf;
   logic                                is_pad, op_fill, op_copy;
   logic [brfc_pkg::COUNT_W-1:0]        cnt_lo_val, cnt_dec;
   brfc_pkg::err_type                   err;
   logic                                emit, ok_end;
   logic                                done_beat, err_beat, rearmed, draining;

   assign b          = beat.packed_byte;
   assign last       = beat.last_byte;
   assign cap        = {1'b0, dest_paragraphs, 4'b0000};
   assign sum_fill   = prod_ff + {{(brfc_pkg::PROD_W-brfc_pkg::COUNT_W){1'b0}}, count_ff};
   assign sum_lit    = prod_ff + {{(brfc_pkg::PROD_W-1){1'b0}}, 1'b1};
   assign fill_ovf   = sum_fill > cap;
   assign lit_ovf    = sum_lit > cap;
   assign is_pad     = (phase_ff == brfc_pkg::PH_SKIP) && (b == brfc_pkg::PAD_BYTE);
   assign op_fill    = b[7:1] == brfc_pkg::OP_FILL[7:1];
   assign op_copy    = b[7:1] == brfc_pkg::OP_COPY[7:1];
   assign cnt_lo_val = {count_ff[7:0], b};
   assign cnt_dec    = count_ff - 16'd1;

   // error found by this byte
   always_comb begin
      err = brfc_pkg::ERR_NONE;
      case (phase_ff)
         brfc_pkg::PH_SKIP, brfc_pkg::PH_OPCODE: begin
            if (!is_pad && !op_fill && !op_copy) err = brfc_pkg::ERR_OPCODE;
         end
         brfc_pkg::PH_FILL: begin
            if (fill_ovf) err = brfc_pkg::ERR_OVERFLOW;
         end
         brfc_pkg::PH_LITERAL, brfc_pkg::PH_TAIL: begin
            if (lit_ovf) err = brfc_pkg::ERR_OVERFLOW;
         end
         default: err = brfc_pkg::ERR_NONE;
      endcase
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      final_in = final_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      prod_in  = prod_ff;
      if (step) begin
         if (phase_ff == brfc_pkg::PH_DRAIN || err != brfc_pkg::ERR_NONE || last) begin
            if (last) begin
               phase_in = brfc_pkg::PH_SKIP;
               final_in = 1'b0;
               fill_in  = 1'b0;
               count_in = '0;
               prod_in  = '0;
            end else begin
               phase_in = brfc_pkg::PH_DRAIN;
            end
         end else begin
            case (phase_ff)
               brfc_pkg::PH_SKIP, brfc_pkg::PH_OPCODE: begin
                  if (!is_pad) begin
                     fill_in  = op_fill;
                     final_in = b[0];
                     phase_in = brfc_pkg::PH_CNT_HI;
                  end
               end
               brfc_pkg::PH_CNT_HI: begin
                  count_in = {8'h00, b};
                  phase_in = brfc_pkg::PH_CNT_LO;
               end
               brfc_pkg::PH_CNT_LO: begin
                  count_in = cnt_lo_val;
                  if (fill_ff) begin
                     phase_in = brfc_pkg::PH_FILL;
                  end else if (cnt_lo_val == '0) begin
                     phase_in = final_ff ? brfc_pkg::PH_TAIL : brfc_pkg::PH_OPCODE;
                  end else begin
                     phase_in = brfc_pkg::PH_LITERAL;
                  end
               end
               brfc_pkg::PH_FILL: begin
                  prod_in  = sum_fill;
                  phase_in = final_ff ? brfc_pkg::PH_TAIL : brfc_pkg::PH_OPCODE;
               end
               brfc_pkg::PH_LITERAL: begin
                  prod_in  = sum_lit;
                  count_in = cnt_dec;
                  if (cnt_dec == '0) begin
                     phase_in = final_ff ? brfc_pkg::PH_TAIL : brfc_pkg::PH_OPCODE;
                  end
               end
               brfc_pkg::PH_TAIL: begin
                  prod_in = sum_lit;
               end
               default: phase_in = phase_ff;
            endcase
         end
      end
   end

   // result
   always_comb begin
      emit   = 1'b0;
      ok_end = 1'b0;
      res    = '0;
      case (phase_ff)
         brfc_pkg::PH_CNT_LO: begin
            ok_end = !fill_ff && (cnt_lo_val == '0) && final_ff;
         end
         brfc_pkg::PH_FILL: begin
            emit   = !fill_ovf && (count_ff != '0);
            ok_end = !fill_ovf && final_ff;
         end
         brfc_pkg::PH_LITERAL: begin
            emit   = !lit_ovf;
            ok_end = !lit_ovf && (cnt_dec == '0) && final_ff;
         end
         brfc_pkg::PH_TAIL: begin
            emit   = !lit_ovf;
            ok_end = 1'b1;
         end
         default: begin
            emit   = 1'b0;
            ok_end = 1'b0;
         end
      endcase
      if (step && phase_ff != brfc_pkg::PH_DRAIN) begin
         if (err != brfc_pkg::ERR_NONE) begin
            res.valid    = 1'b1;
            res.done_res = 1'b1;
            res.error    = err;
         end else if (last || emit) begin
            res.valid    = 1'b1;
            res.done_res = last;
            res.error    = (last && !ok_end) ? brfc_pkg::ERR_EARLY : brfc_pkg::ERR_NONE;
            if (emit) begin
               res.out_byte   = b;
               res.repeat_res = (phase_ff == brfc_pkg::PH_FILL) ? count_ff : 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= brfc_pkg::PH_SKIP;
         final_ff <= 1'b0;
         fill_ff  <= 1'b0;
         count_ff <= '0;
         prod_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         final_ff <= final_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
         prod_ff  <= prod_in;
      end
   end

   assign done_beat = step && res.valid && res.done_res && last;
   assign err_beat  = step && res.valid && (res.error != brfc_pkg::ERR_NONE) && !last;
   assign rearmed   = (phase_ff == brfc_pkg::PH_SKIP) && (prod_ff == '0);
   assign draining  = phase_ff == brfc_pkg::PH_DRAIN;

   `BRFC_ASSERT_NEXT(a_done_rearms, done_beat, rearmed, "stream not rearmed after last beat")
   `BRFC_ASSERT_NEXT(a_error_drains, err_beat, draining, "error did not enter drain")
   `BRFC_ASSERT_IMPLY(a_drain_silent, draining, !res.valid, "result produced while draining")

endmodule
`default_nettype wire

[hw/rtl/brfc_out_reg.sv]
// result register: holds one result beat until the consumer takes it
`timescale 1ns / 1ps
`default_nettype none
module brfc_out_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire brfc_pkg::res_type res,
   input  wire logic              rsp_ready,
   output      logic              free,
   output      logic              rsp_valid,
   output      brfc_pkg::res_type rsp_res
);

   logic              valid_ff, valid_in;
   brfc_pkg::res_type res_ff, res_in;

   assign free      = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (load) begin
         valid_in = res.valid;
         res_in   = res;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

endmodule
`default_nettype wire
